### design/midpoint_circle_rasterizer_assert.svh
// Assertion macros shared by the rasterizer modules.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MCR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MCR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define MCR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### design/mcr_pkg.sv
package mcr_pkg;

  localparam int OUT_BITS = 16;
  localparam int COORD_BITS_DEF = 15;
  localparam int RADIUS_BITS_DEF = 12;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILL     = 2'd3;

  localparam int SLOT_BITS = 3;
  localparam logic [SLOT_BITS-1:0] LAST_SLOT_OUTLINE = 3'd7;
  localparam logic [SLOT_BITS-1:0] LAST_SLOT_FILL    = 3'd3;

  typedef struct packed {
    logic launch;
    logic fill;
    logic fin;
  } job_ctl_t;

endpackage

### design/mcr_walker.sv
`include "midpoint_circle_rasterizer_assert.svh"

module mcr_walker #(
  parameter int COORD_BITS  = 15,
  parameter int RADIUS_BITS = 12,
  parameter int CFG_BITS    = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mcr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]                 cfg_data,
  input  logic                                in_valid,
  input  logic                                in_restart,
  output logic                                in_ready,
  input  logic                                emit_ready,
  output mcr_pkg::job_ctl_t                   job_ctl,
  output logic signed [RADIUS_BITS+1:0]       job_x,
  output logic signed [RADIUS_BITS+1:0]       job_y,
  output logic signed [COORD_BITS-1:0]        job_cx,
  output logic signed [COORD_BITS-1:0]        job_cy
);
  import mcr_pkg::*;

  localparam int XW = RADIUS_BITS + 2;
  localparam int EW = RADIUS_BITS + 4;

  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [RADIUS_BITS-1:0]       circle_radius;
  logic                         fill_mode;

  logic signed [XW-1:0] walk_x;
  logic signed [XW-1:0] walk_y;
  logic signed [EW-1:0] decision_error;
  logic                 walk_done;

  logic signed [XW-1:0] x_cur, y_cur, x_next, y_next;
  logic signed [EW-1:0] e_cur, e_next;
  logic                 done_cur, behind, fin, accept;

  assign in_ready = emit_ready;
  assign accept   = in_valid & emit_ready;

  always_comb begin
    if (in_restart) begin
      x_cur    = $signed({2'b00, circle_radius});
      y_cur    = '0;
      e_cur    = EW'(1) - $signed({4'b0000, circle_radius});
      done_cur = 1'b0;
    end else begin
      x_cur    = walk_x;
      y_cur    = walk_y;
      e_cur    = decision_error;
      done_cur = walk_done;
    end
    behind = x_cur < y_cur;
    y_next = y_cur + XW'(1);
    if (e_cur[EW-1]) begin
      x_next = x_cur;
      e_next = e_cur + (EW'(y_next) <<< 1) + EW'(1);
    end else begin
      x_next = x_cur - XW'(1);
      e_next = e_cur + ((EW'(y_next) - EW'(x_next)) <<< 1) + EW'(1);
    end
    fin = x_next < y_next;
  end

  assign job_ctl.launch = accept & ~done_cur & ~behind;
  assign job_ctl.fill   = fill_mode;
  assign job_ctl.fin    = fin;
  assign job_x          = x_cur;
  assign job_y          = y_cur;
  assign job_cx         = center_x;
  assign job_cy         = center_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      circle_radius  <= '0;
      fill_mode      <= 1'b0;
      walk_x         <= '0;
      walk_y         <= '0;
      decision_error <= '0;
      walk_done      <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CENTER_X: center_x      <= cfg_data[COORD_BITS-1:0];
          REG_CENTER_Y: center_y      <= cfg_data[COORD_BITS-1:0];
          REG_RADIUS:   circle_radius <= cfg_data[RADIUS_BITS-1:0];
          REG_FILL:     fill_mode     <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept && !done_cur) begin
        if (behind) begin
          walk_x         <= x_cur;
          walk_y         <= y_cur;
          decision_error <= e_cur;
          walk_done      <= 1'b1;
        end else begin
          walk_x         <= x_next;
          walk_y         <= y_next;
          decision_error <= e_next;
          walk_done      <= fin;
        end
      end
    end
  end

  `MCR_ASSERT_IMP(a_active_in_octant, clk, rst, !walk_done, !(walk_x < walk_y), "walk past octant")
  `MCR_ASSERT_NXT(a_idle_step_holds, clk, rst, accept && !in_restart && walk_done, walk_done && $stable(walk_x) && $stable(walk_y), "idle step changed walk")

endmodule

### design/mcr_emitter.sv
`include "midpoint_circle_rasterizer_assert.svh"

module mcr_emitter #(
  parameter int COORD_BITS  = 15,
  parameter int RADIUS_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mcr_pkg::job_ctl_t                   job_ctl,
  input  logic signed [RADIUS_BITS+1:0]       job_x,
  input  logic signed [RADIUS_BITS+1:0]       job_y,
  input  logic signed [COORD_BITS-1:0]        job_cx,
  input  logic signed [COORD_BITS-1:0]        job_cy,
  output logic                                emit_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mcr_pkg::OUT_BITS-1:0]        out_left,
  output logic [mcr_pkg::OUT_BITS-1:0]        out_right,
  output logic [mcr_pkg::OUT_BITS-1:0]        out_row,
  output logic                                out_last,
  output logic                                out_fin
);
  import mcr_pkg::*;

  localparam int XW = RADIUS_BITS + 2;
  localparam int SW = ((COORD_BITS > XW) ? COORD_BITS : XW) + 1;
  localparam int CW = (SW > OUT_BITS) ? SW : OUT_BITS;

  logic                         job_valid;
  logic [SLOT_BITS-1:0]         slot;
  logic signed [XW-1:0]         x, y;
  logic signed [COORD_BITS-1:0] cx, cy;
  logic                         fill, fin;

  logic                 load_out, job_done;
  logic [SLOT_BITS-1:0] last_slot;
  logic signed [CW-1:0] cxpx, cxmx, cxpy, cxmy, cypx, cymx, cypy, cymy;
  logic signed [CW-1:0] sel_l, sel_r, sel_row;

  assign last_slot  = fill ? LAST_SLOT_FILL : LAST_SLOT_OUTLINE;
  assign load_out   = job_valid & (~out_valid | out_ready);
  assign job_done   = load_out & (slot == last_slot);
  assign emit_ready = ~job_valid | job_done;

  always_comb begin
    cxpx = CW'(cx) + CW'(x);
    cxmx = CW'(cx) - CW'(x);
    cxpy = CW'(cx) + CW'(y);
    cxmy = CW'(cx) - CW'(y);
    cypx = CW'(cy) + CW'(x);
    cymx = CW'(cy) - CW'(x);
    cypy = CW'(cy) + CW'(y);
    cymy = CW'(cy) - CW'(y);
    if (fill) begin
      case (slot[1:0])
        2'd0:    begin sel_l = cxmx; sel_r = cxpx; sel_row = cypy; end
        2'd1:    begin sel_l = cxmy; sel_r = cxpy; sel_row = cypx; end
        2'd2:    begin sel_l = cxmx; sel_r = cxpx; sel_row = cymy; end
        default: begin sel_l = cxmy; sel_r = cxpy; sel_row = cymx; end
      endcase
    end else begin
      case (slot)
        3'd0:    begin sel_l = cxpx; sel_row = cypy; end
        3'd1:    begin sel_l = cxpy; sel_row = cypx; end
        3'd2:    begin sel_l = cxmy; sel_row = cypx; end
        3'd3:    begin sel_l = cxmx; sel_row = cypy; end
        3'd4:    begin sel_l = cxmx; sel_row = cymy; end
        3'd5:    begin sel_l = cxmy; sel_row = cymx; end
        3'd6:    begin sel_l = cxpy; sel_row = cymx; end
        default: begin sel_l = cxpx; sel_row = cymy; end
      endcase
      sel_r = sel_l;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (job_ctl.launch) begin
        job_valid <= 1'b1;
        slot      <= '0;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end else if (load_out) begin
        slot <= slot + SLOT_BITS'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_ctl.launch) begin
      x    <= job_x;
      y    <= job_y;
      cx   <= job_cx;
      cy   <= job_cy;
      fill <= job_ctl.fill;
      fin  <= job_ctl.fin;
    end
    if (load_out) begin
      out_left  <= sel_l[OUT_BITS-1:0];
      out_right <= sel_r[OUT_BITS-1:0];
      out_row   <= sel_row[OUT_BITS-1:0];
      out_last  <= slot == last_slot;
      out_fin   <= fin;
    end
  end

  `MCR_ASSERT_IMP(a_launch_when_free, clk, rst, job_ctl.launch, !job_valid || job_done, "request launched over busy job")
  `MCR_ASSERT_IMP(a_fill_slot_range, clk, rst, job_valid && fill, slot <= LAST_SLOT_FILL, "fill slot out of range")
  `MCR_ASSERT_NXT(a_done_marks_last, clk, rst, job_done, out_valid && out_last, "last result not marked")

endmodule

### design/midpoint_circle_rasterizer.sv
// An accepted step request is registered into the span emitter, each result then into its
// output register. One result per cycle while m_axis_tready allows; a step yields 8 spans
// in outline mode, 4 in fill mode, none when the walk is finished or idle; the next step is
// accepted as its last span loads. Reset (rst, synchronous, active high): configuration
// and walk coordinates clear to zero, no circle active, no result pending.
module midpoint_circle_rasterizer #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
  parameter int CFG_BITS    = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mcr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]                cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [0] restart, [7:1] zero
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [47:0]                        m_axis_tdata,  // span_left, span_right, span_row
  output logic                               m_axis_tlast,
  output logic [0:0]                         m_axis_tuser   // circle_finished
);
  import mcr_pkg::*;

  job_ctl_t                     job_ctl;
  logic signed [RADIUS_BITS+1:0] job_x, job_y;
  logic signed [COORD_BITS-1:0]  job_cx, job_cy;
  logic                          emit_ready;
  logic [OUT_BITS-1:0]           span_left, span_right, span_row;
  logic                          circle_finished;

  mcr_walker #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS),
    .CFG_BITS   (CFG_BITS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_restart(s_axis_tdata[0]),
    .in_ready  (s_axis_tready),
    .emit_ready(emit_ready),
    .job_ctl   (job_ctl),
    .job_x     (job_x),
    .job_y     (job_y),
    .job_cx    (job_cx),
    .job_cy    (job_cy)
  );

  mcr_emitter #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_emitter (
    .clk       (clk),
    .rst       (rst),
    .job_ctl   (job_ctl),
    .job_x     (job_x),
    .job_y     (job_y),
    .job_cx    (job_cx),
    .job_cy    (job_cy),
    .emit_ready(emit_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_left  (span_left),
    .out_right (span_right),
    .out_row   (span_row),
    .out_last  (m_axis_tlast),
    .out_fin   (circle_finished)
  );

  assign m_axis_tdata    = {span_row, span_right, span_left};
  assign m_axis_tuser[0] = circle_finished;

endmodule

### sim/tb_midpoint_circle_rasterizer.sv
`timescale 1ns / 1ps

module tb_midpoint_circle_rasterizer;
  import mcr_pkg::*;

  localparam int COORD_W = COORD_BITS_DEF;
  localparam int RADIUS_W = RADIUS_BITS_DEF;
  localparam int CFG_W = (COORD_W > RADIUS_W) ? COORD_W : RADIUS_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int STEP_TOTAL = 480;

  typedef struct packed {
    logic               fin;
    logic               last;
    logic signed [15:0] row;
    logic signed [15:0] right;
    logic signed [15:0] left;
  } span_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata = '0;  // [0] restart, [7:1] zero
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [47:0]               m_axis_tdata;  // span_left, span_right, span_row
  logic                      m_axis_tlast;
  logic [0:0]                m_axis_tuser;  // circle_finished

  midpoint_circle_rasterizer DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk = ~clk;

  // step requests waiting to be offered, and spans the circle walk predicts
  bit    step_reqs[$];
  span_t pending_spans[$];
  int    req_total = 0;
  int    errors = 0;
  int    cycle_cnt = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    plan_rad = 0;
  bit    hold_tog = 1'b0;
  bit    hold_ack = 1'b0;
  int    hold_left = 0;
  bit    in_taken = 1'b0;

  // shadow of the registers and of the walk
  int org_x = 0;
  int org_y = 0;
  int rad_cfg = 0;
  bit fill_cfg = 1'b0;
  int trace_x = 0;
  int trace_y = 0;
  int trace_err = 0;
  bit trace_idle = 1'b1;

  task automatic apply_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CFG_W-1:0] d);
    case (idx)
      REG_CENTER_X: org_x = $signed(d[COORD_W-1:0]);
      REG_CENTER_Y: org_y = $signed(d[COORD_W-1:0]);
      REG_RADIUS:   rad_cfg = int'(d[RADIUS_W-1:0]);
      REG_FILL:     fill_cfg = d[0];
      default: ;
    endcase
  endtask

  task automatic walk_step(input bit restart);
    int    x, y, n;
    int    lc[8];
    int    rc[8];
    int    rw[8];
    bit    fin;
    span_t sp;
    if (restart) begin
      trace_x = rad_cfg;
      trace_y = 0;
      trace_err = 1 - rad_cfg;
      trace_idle = 1'b0;
    end
    if (!trace_idle) begin
      if (trace_x < trace_y) begin
        trace_idle = 1'b1;
      end else begin
        x = trace_x;
        y = trace_y;
        if (fill_cfg) begin
          lc[0] = org_x - x; rc[0] = org_x + x; rw[0] = org_y + y;
          lc[1] = org_x - y; rc[1] = org_x + y; rw[1] = org_y + x;
          lc[2] = org_x - x; rc[2] = org_x + x; rw[2] = org_y - y;
          lc[3] = org_x - y; rc[3] = org_x + y; rw[3] = org_y - x;
          n = 4;
        end else begin
          lc[0] = org_x + x; rw[0] = org_y + y;
          lc[1] = org_x + y; rw[1] = org_y + x;
          lc[2] = org_x - y; rw[2] = org_y + x;
          lc[3] = org_x - x; rw[3] = org_y + y;
          lc[4] = org_x - x; rw[4] = org_y - y;
          lc[5] = org_x - y; rw[5] = org_y - x;
          lc[6] = org_x + y; rw[6] = org_y - x;
          lc[7] = org_x + x; rw[7] = org_y - y;
          rc = lc;
          n = 8;
        end
        y++;
        if (trace_err < 0) begin
          trace_err += 2 * y + 1;
        end else begin
          x--;
          trace_err += 2 * (y - x) + 1;
        end
        trace_x = x;
        trace_y = y;
        fin = (x < y);
        if (fin) trace_idle = 1'b1;
        for (int k = 0; k < n; k++) begin
          sp.left = lc[k][15:0];
          sp.right = rc[k][15:0];
          sp.row = rw[k][15:0];
          sp.last = (k == n - 1);
          sp.fin = fin;
          pending_spans.push_back(sp);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** midpoint_circle_rasterizer: FAILED **");
      $finish;
    end
  end

  // monitor: register shadow, prediction on accepted requests, result check
  always @(posedge clk) begin
    span_t act, exp_sp;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) walk_step(s_axis_tdata[0]);
      if (m_axis_tvalid && m_axis_tready) begin
        act = {m_axis_tuser[0], m_axis_tlast, m_axis_tdata};
        if (pending_spans.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, act);
          errors <= errors + 1;
        end else begin
          exp_sp = pending_spans.pop_front();
          if (act !== exp_sp) begin
            $display("%0t mismatch: expected %h actual %h", $time, exp_sp, act);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (step_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata <= {7'b0, step_reqs.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, with a long hold-off when the stimulus toggles hold_tog
  always @(negedge clk) begin
    if (hold_tog != hold_ack) begin
      hold_ack <= hold_tog;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic offer(input bit restart);
    step_reqs.push_back(restart);
    req_total++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CFG_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    if (idx == REG_RADIUS) plan_rad = int'(d[RADIUS_W-1:0]);
  endtask

  task automatic writes_done();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_circle(input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                            input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] f);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIUS, r);
    write_reg(REG_FILL, f);
    writes_done();
  endtask

  // wait for the block to drain; idle steps leave no result, so allow their latency
  task automatic settle();
    while (step_reqs.size() > 0 || s_axis_tvalid || pending_spans.size() > 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_idle();
    if (req_total < 180) begin
      send_idle_pct = 14;
      recv_idle_pct = 51;
    end else if (req_total < 340) begin
      send_idle_pct = 51;
      recv_idle_pct = 14;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_center();
    int p;
    p = $urandom_range(99);
    if (p < 10) return 15'h4000;
    if (p < 20) return 15'h3FFF;
    return CFG_W'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] pick_radius();
    int p;
    p = $urandom_range(99);
    if (p < 65) return CFG_W'($urandom_range(0, 12));
    if (p < 88) return CFG_W'($urandom_range(13, 60));
    if (p < 95) return CFG_W'($urandom);
    if (p < 97) return '0;
    return (p < 99) ? CFG_W'(4095) : 15'h7FFF;
  endfunction

  initial begin : stimulus
    int  seqs, kk;
    bit  held;
    held = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    set_idle();

    // steps with no circle active
    offer(1'b0);
    offer(1'b0);
    settle();
    // zero radius, outline then fill, plus a step after the walk ended
    set_circle('0, '0, '0, '0);
    offer(1'b1);
    offer(1'b0);
    settle();
    write_reg(REG_FILL, 15'h0001);
    writes_done();
    offer(1'b1);
    settle();
    // extreme centers, radius beyond its width
    set_circle(15'h4000, 15'h3FFF, 15'h7FFF, '0);
    offer(1'b1);
    offer(1'b0);
    offer(1'b0);
    settle();
    // registers changed during the walk
    write_reg(REG_CENTER_X, 15'h3FFF);
    write_reg(REG_CENTER_Y, 15'h4000);
    write_reg(REG_FILL, 15'h7FFF);
    writes_done();
    offer(1'b0);
    offer(1'b0);
    offer(1'b1);
    settle();
    // small circle with a restart in the middle
    set_circle(CFG_W'(100), CFG_W'(-50), CFG_W'(5), '0);
    offer(1'b1);
    offer(1'b0);
    offer(1'b0);
    offer(1'b1);
    offer(1'b0);
    offer(1'b0);
    settle();
    write_reg(REG_CENTER_X, CFG_W'(-7));
    write_reg(REG_FILL, 15'h0001);
    writes_done();
    repeat (5) offer(1'b0);
    settle();

    while (req_total < STEP_TOTAL) begin
      set_idle();
      if (!held && req_total >= 340) begin
        // receiver holds off while a long walk is queued
        held = 1'b1;
        write_reg(REG_RADIUS, CFG_W'(20));
        write_reg(REG_FILL, '0);
        writes_done();
        hold_tog = ~hold_tog;
        offer(1'b1);
        repeat (17) offer(1'b0);
        settle();
      end
      if ($urandom_range(99) < 60) write_reg(REG_CENTER_X, pick_center());
      if ($urandom_range(99) < 60) write_reg(REG_CENTER_Y, pick_center());
      if ($urandom_range(99) < 60) write_reg(REG_RADIUS, pick_radius());
      if ($urandom_range(99) < 50) write_reg(REG_FILL, CFG_W'($urandom));
      writes_done();
      seqs = $urandom_range(1, 4);
      for (int s = 0; s < seqs; s++) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 4)) offer(1'($urandom_range(1)));
        end else begin
          if (!(s == 0 && $urandom_range(3) == 0)) offer(1'b1);
          kk = (plan_rad * 3) / 4 + $urandom_range(1, 3);
          if (kk > 40) kk = $urandom_range(2, 40);
          for (int j = 0; j < kk; j++) begin
            if ($urandom_range(19) == 0) offer(1'($urandom_range(1)));
            else offer(1'b0);
          end
        end
      end
      settle();
    end

    settle();
    if (errors == 0 && pending_spans.size() == 0) begin
      $display("** midpoint_circle_rasterizer: PASSED **");
    end else begin
      $display("** midpoint_circle_rasterizer: FAILED **");
    end
    $finish;
  end

endmodule
